FILE: design/tli_pkg.sv
// ----------------------------------------------------------------------------
// tli_pkg
// Shared types and constants for the table linear interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tli_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned COUNT_W  = 7;

  // Codes of the input kind field.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Command queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // One queued command. For a query, x carries the query abscissa.
  typedef struct packed {
    logic                 is_query;
    logic [INDEX_W-1:0]   index;
    logic [DATA_W-1:0]    x;
    logic [DATA_W-1:0]    y;
  } cmd_t;

endpackage

`default_nettype wire

FILE: design/tli_fifo.sv
// ----------------------------------------------------------------------------
// tli_fifo
// Short command queue that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tli_fifo
  import tli_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output cmd_t      head_cmd,
  output logic      head_valid
);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("command queue count beyond depth");

endmodule

`default_nettype wire

FILE: design/tli_front.sv
// ----------------------------------------------------------------------------
// tli_front
// Input stage: takes items, drops writes outside the table and queues the rest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tli_front
  import tli_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_kind,
  input  wire logic [INDEX_W-1:0] in_point_index,
  input  wire logic [DATA_W-1:0]  in_point_x,
  input  wire logic [DATA_W-1:0]  in_point_y,
  input  wire logic [DATA_W-1:0]  in_query_value,
  output logic                    push,
  output cmd_t                    push_cmd,
  input  wire logic               queue_full
);

  cmd_t stage_r;
  logic stage_valid_r;
  logic in_range;
  logic keep;

  assign in_range = (int'(in_point_index) < MAX_POINTS);
  assign keep     = (in_kind == KIND_QUERY) || in_range;
  assign push     = stage_valid_r;
  assign push_cmd = stage_r;
  assign in_ready = !stage_valid_r || !queue_full;

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_r.is_query <= (in_kind == KIND_QUERY);
      stage_r.index    <= in_point_index;
      stage_r.x        <= (in_kind == KIND_QUERY) ? in_query_value : in_point_x;
      stage_r.y        <= in_point_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_ready) begin
      // A write to an index outside the table is consumed without effect.
      stage_valid_r <= in_valid && keep;
    end
  end

endmodule

`default_nettype wire

FILE: design/tli_back.sv
// ----------------------------------------------------------------------------
// tli_back
// Execution engine: holds the breakpoint table, searches it, interpolates
// with a multiplier and a bit-serial divider, and drives the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tli_back
  import tli_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [COUNT_W-1:0] points_in_use,
  input  wire cmd_t               head_cmd,
  input  wire logic               head_valid,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [DATA_W-1:0]       out_interp_value,
  output logic [DATA_W-1:0]       out_product_value,
  output logic                    out_product_saturated
);

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FIRST = 4'd1;
  localparam logic [3:0] S_LAST  = 4'd2;
  localparam logic [3:0] S_SRCH  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_DSET  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_ADJ   = 4'd7;
  localparam logic [3:0] S_PROD  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [2*DATA_W-1:0] mem [MAX_POINTS];
  logic [2*DATA_W-1:0] rd_data_r;
  logic [AW-1:0]       rd_addr;
  logic                mem_we;
  logic [DATA_W-1:0]   rd_x;
  logic [DATA_W-1:0]   rd_y;

  logic [3:0]          state_r, state_nxt;
  logic [AW-1:0]       last_idx;
  logic [AW-1:0]       hi_r;
  logic [DATA_W-1:0]   q_r;
  logic [DATA_W-1:0]   xlo_r;
  logic [DATA_W-1:0]   ylo_r;
  logic [DATA_W-1:0]   a_r;
  logic [DATA_W-1:0]   b_r;
  logic [DATA_W-1:0]   dx_r;
  logic                neg_r;
  logic [2*DATA_W-1:0] num_r;
  logic [DATA_W-1:0]   rem_r;
  logic [DATA_W-1:0]   quo_r;
  logic [4:0]          cnt_r;
  logic [DATA_W:0]     shifted;
  logic                fits;
  logic [DATA_W-1:0]   v_r;
  logic [2*DATA_W-1:0] pm_r;
  logic                out_free;
  logic                stop;

  logic                out_valid_r;
  logic [DATA_W-1:0]   out_interp_r;
  logic [DATA_W-1:0]   out_product_r;
  logic                out_sat_r;

  assign out_valid             = out_valid_r;
  assign out_interp_value      = out_interp_r;
  assign out_product_value     = out_product_r;
  assign out_product_saturated = out_sat_r;

  assign rd_x = rd_data_r[2*DATA_W-1:DATA_W];
  assign rd_y = rd_data_r[DATA_W-1:0];

  // The register value is clamped into the usable range of the table.
  always_comb begin
    if (points_in_use < COUNT_W'(2)) begin
      last_idx = AW'(1);
    end else if (int'(points_in_use) > MAX_POINTS) begin
      last_idx = AW'(MAX_POINTS - 1);
    end else begin
      last_idx = AW'(points_in_use - COUNT_W'(1));
    end
  end

  assign pop      = (state_r == S_IDLE) && head_valid;
  assign mem_we   = pop && !head_cmd.is_query;
  assign out_free = !out_valid_r || out_ready;
  assign stop     = (hi_r == last_idx) || (rd_x >= q_r);
  assign shifted  = {rem_r, quo_r[DATA_W-1]};
  assign fits     = (shifted >= {1'b0, dx_r});

  always_comb begin
    case (state_r)
      S_FIRST: rd_addr = last_idx;
      S_LAST:  rd_addr = AW'(1);
      S_SRCH:  rd_addr = hi_r + AW'(1);
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(head_cmd.index)] <= {head_cmd.x, head_cmd.y};
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (pop && head_cmd.is_query) state_nxt = S_FIRST;
      S_FIRST: state_nxt = (q_r <= rd_x) ? S_PROD : S_LAST;
      S_LAST:  state_nxt = (q_r >= rd_x) ? S_PROD : S_SRCH;
      S_SRCH:  if (stop) state_nxt = S_MUL;
      S_MUL:   state_nxt = (dx_r == '0) ? S_PROD : S_DSET;
      S_DSET:  state_nxt = S_DIV;
      S_DIV:   if (cnt_r == 5'd31) state_nxt = S_ADJ;
      S_ADJ:   state_nxt = S_PROD;
      S_PROD:  state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        q_r <= head_cmd.x;
      end
      S_FIRST: begin
        xlo_r <= rd_x;
        ylo_r <= rd_y;
        v_r   <= rd_y;
      end
      S_LAST: begin
        v_r  <= rd_y;
        hi_r <= AW'(1);
      end
      S_SRCH: begin
        if (stop) begin
          a_r  <= q_r - xlo_r;
          dx_r <= rd_x - xlo_r;
          if (rd_y >= ylo_r) begin
            b_r   <= rd_y - ylo_r;
            neg_r <= 1'b0;
          end else begin
            b_r   <= ylo_r - rd_y;
            neg_r <= 1'b1;
          end
        end else begin
          xlo_r <= rd_x;
          ylo_r <= rd_y;
          hi_r  <= hi_r + AW'(1);
        end
      end
      S_MUL: begin
        num_r <= a_r * b_r;
        v_r   <= ylo_r;
      end
      S_DSET: begin
        // The quotient fits in 32 bits, so the upper half is below the divisor.
        rem_r <= num_r[2*DATA_W-1:DATA_W];
        quo_r <= num_r[DATA_W-1:0];
        cnt_r <= '0;
      end
      S_DIV: begin
        rem_r <= fits ? DATA_W'(shifted - {1'b0, dx_r}) : shifted[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], fits};
        cnt_r <= cnt_r + 5'd1;
      end
      S_ADJ: begin
        v_r <= neg_r ? (ylo_r - quo_r) : (ylo_r + quo_r);
      end
      S_PROD: begin
        pm_r <= q_r * v_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && out_free) begin
      out_interp_r <= v_r;
      if (pm_r[2*DATA_W-1:DATA_W+16] != '0) begin
        out_product_r <= '1;
        out_sat_r     <= 1'b1;
      end else begin
        out_product_r <= pm_r[DATA_W+15:16];
        out_sat_r     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (dx_r != '0))
    else $error("division started with a zero interval");

  a_div_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && (cnt_r == 5'd0) |-> (rem_r < dx_r))
    else $error("interpolation quotient overflows 32 bits");

  a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH) |-> (hi_r != '0) && (hi_r <= last_idx))
    else $error("search index outside the active table");

  a_out_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) && out_valid_r && !out_ready |=> (state_r == S_OUT))
    else $error("result overwrote a pending transfer");

endmodule

`default_nettype wire

FILE: design/table_linear_interpolator_core.sv
// A write passes the front stage register and the command queue and is written to
// the table when the back pops it in S_IDLE; it has no result. A query clamped at the
// first breakpoint runs S_FIRST, S_PROD and S_OUT; one clamped at the last adds S_LAST;
// an interpolated one adds S_SRCH, S_MUL, S_DSET, S_DIV and S_ADJ: one table read and
// one quotient bit per cycle, a zero interval skipping the divider. One query at a time;
// S_OUT waits for a free output. Reset sets points_in_use to 2, table undefined.
// ----------------------------------------------------------------------------
// table_linear_interpolator_core
// Piecewise linear interpolation over a loaded Q16.16 breakpoint table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module table_linear_interpolator_core
  import tli_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [COUNT_W-1:0] cfg_points_in_use,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_kind,
  input  wire logic [INDEX_W-1:0] in_point_index,
  input  wire logic [DATA_W-1:0]  in_point_x,
  input  wire logic [DATA_W-1:0]  in_point_y,
  input  wire logic [DATA_W-1:0]  in_query_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [DATA_W-1:0]       out_interp_value,
  output logic [DATA_W-1:0]       out_product_value,
  output logic                    out_product_saturated
);

  logic [COUNT_W-1:0] points_r;
  logic               push;
  cmd_t               push_cmd;
  logic               queue_full;
  logic               pop;
  cmd_t               head_cmd;
  logic               head_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r <= COUNT_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      points_r <= cfg_points_in_use;
    end
  end

  tli_front #(
    .MAX_POINTS(MAX_POINTS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_point_index (in_point_index),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_query_value (in_query_value),
    .push           (push),
    .push_cmd       (push_cmd),
    .queue_full     (queue_full)
  );

  tli_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop        (pop),
    .head_cmd   (head_cmd),
    .head_valid (head_valid)
  );

  tli_back #(
    .MAX_POINTS(MAX_POINTS)
  ) u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .points_in_use         (points_r),
    .head_cmd              (head_cmd),
    .head_valid            (head_valid),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_interp_value      (out_interp_value),
    .out_product_value     (out_product_value),
    .out_product_saturated (out_product_saturated)
  );

endmodule

`default_nettype wire
